// ===== rtl/dvfb_pkg.sv =====
`default_nettype none

package dvfb_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FORM_BITS     = 3'd0;
  localparam logic [2:0] CFG_UNIT_BITS     = 3'd1;
  localparam logic [2:0] CFG_FRAME_LENGTH  = 3'd2;
  localparam logic [2:0] CFG_TEMPLATE_LOW  = 3'd3;
  localparam logic [2:0] CFG_TEMPLATE_HIGH = 3'd4;

  // Register reset values.
  localparam logic [6:0] FORM_BITS_RST    = 7'd64;
  localparam logic [7:0] UNIT_BITS_RST    = 8'd96;
  localparam logic [4:0] FRAME_LENGTH_RST = 5'd15;

  // Shortest frame that still holds the value bytes and the checksum.
  localparam int unsigned MIN_FRAME = 7;

  // Largest magnitude that is shown; anything above reads as zero.
  localparam logic [15:0] MAX_MAGNITUDE = 16'd9999;

  // Queue between the digit front end and the byte sequencer.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Sign and four decimal digits of one measurement.
  typedef struct packed {
    logic       neg;
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } dvfb_digits_t;

  // Queue status seen by the sequencer and the top level.
  typedef struct packed {
    logic              valid;
    logic [QCNT_W-1:0] count;
  } dvfb_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/dvfb_front.sv =====
`default_nettype none

module dvfb_front
  import dvfb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire logic signed [15:0] value_i,
  output logic [1:0]              busy_o,
  output logic                    busy3_o,
  output logic                    push_o,
  output dvfb_digits_t            digits_o
);

  // Stage 1: sign and clamped magnitude.
  logic        v1_q;
  logic        neg1_q;
  logic [13:0] mag1_q;
  // Stage 2: thousands digit.
  logic        v2_q;
  logic        neg2_q;
  logic [13:0] mag2_q;
  logic [3:0]  d3_2_q;
  // Stage 3: hundreds digit and remainder below one thousand.
  logic        v3_q;
  logic        neg3_q;
  logic [3:0]  d3_3_q;
  logic [3:0]  d2_3_q;
  logic [9:0]  rem1_3_q;

  logic        neg_in;
  logic [15:0] abs_in;
  logic [13:0] mag_in;
  logic [27:0] prod3;
  logic [13:0] rem1_full;
  logic [15:0] prod2;
  logic [6:0]  rem2;
  logic [14:0] prod1;
  logic [6:0]  d0_full;

  // Absolute value; the most negative input lands above the limit and shows as zero.
  always_comb begin
    neg_in = value_i[15];
    abs_in = neg_in ? (~value_i + 16'd1) : value_i;
    mag_in = (abs_in > MAX_MAGNITUDE) ? 14'd0 : abs_in[13:0];
  end

  // Division by 1000 through a reciprocal; exact for magnitudes up to 9999.
  assign prod3 = 28'(mag1_q) * 28'd8389;

  // Remainder below 1000, then division by 100 through a reciprocal.
  assign rem1_full = mag2_q - 14'(d3_2_q) * 14'd1000;
  assign prod2     = 16'(rem1_full[9:0]) * 16'd41;

  // Remainder below 100, then tens and ones.
  assign rem2    = 7'(rem1_3_q - 10'(d2_3_q) * 10'd100);
  assign prod1   = 15'(rem2) * 15'd205;
  assign d0_full = rem2 - 7'(prod1[14:11]) * 7'd10;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= take_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Payload stages need no reset.
  always_ff @(posedge clk_i) begin
    neg1_q   <= neg_in;
    mag1_q   <= mag_in;
    neg2_q   <= neg1_q;
    mag2_q   <= mag1_q;
    d3_2_q   <= prod3[26:23];
    neg3_q   <= neg2_q;
    d3_3_q   <= d3_2_q;
    d2_3_q   <= prod2[15:12];
    rem1_3_q <= rem1_full[9:0];
  end

  assign busy_o   = {v2_q, v1_q};
  assign busy3_o  = v3_q;
  assign push_o   = v3_q;
  assign digits_o = '{neg: neg3_q, d3: d3_3_q, d2: d2_3_q,
                      d1: prod1[14:11], d0: d0_full[3:0]};

endmodule

`default_nettype wire

// ===== rtl/dvfb_queue.sv =====
`default_nettype none

module dvfb_queue
  import dvfb_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire dvfb_digits_t  push_data_i,
  input  wire logic          pop_i,
  output dvfb_qstat_t        stat_o,
  output dvfb_digits_t       head_o
);

  dvfb_digits_t      mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q;
  logic [QPTR_W-1:0] rptr_q;
  logic [QCNT_W-1:0] count_q;
  logic [QCNT_W-1:0] count_d;

  // Occupancy follows pushes and pops; the front end never pushes into a full queue.
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  assign stat_o = '{valid: (count_q != '0), count: count_q};
  assign head_o = mem_q[rptr_q];

endmodule

`default_nettype wire

// ===== rtl/dvfb_back.sv =====
`default_nettype none

module dvfb_back
  import dvfb_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire dvfb_qstat_t  qstat_i,
  input  wire dvfb_digits_t head_i,
  output logic              pop_o,
  input  wire logic [6:0]   form_bits_i,
  input  wire logic [7:0]   unit_bits_i,
  input  wire logic [4:0]   frame_length_i,
  input  wire logic [63:0]  template_low_i,
  input  wire logic [63:0]  template_high_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              frame_end_o
);

  localparam int unsigned PW = $clog2(MAX_FRAME);

  dvfb_digits_t  cur_q;
  logic          busy_q;
  logic [PW-1:0] pos_q;
  logic [7:0]    sum_q;
  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  logic          frame_end_q;

  logic [4:0]    len_eff;
  logic [PW-1:0] last_pos;
  logic          load;
  logic          emit;
  logic          last;
  logic [127:0]  tmpl;
  logic [6:0]    tmpl_sh;
  logic [7:0]    body_byte;
  logic [7:0]    cur_byte;

  // Effective frame length, clamped to the supported range.
  always_comb begin
    if (frame_length_i < 5'(MIN_FRAME)) begin
      len_eff = 5'(MIN_FRAME);
    end else if (frame_length_i > 5'(MAX_FRAME)) begin
      len_eff = 5'(MAX_FRAME);
    end else begin
      len_eff = frame_length_i;
    end
    last_pos = PW'(len_eff - 5'd1);
  end

  // The output register takes a new word when it is empty or being drained.
  assign load  = !out_valid_q || !out_stall_i;
  assign emit  = busy_q && load;
  assign last  = (pos_q == last_pos);
  assign pop_o = qstat_i.valid && (!busy_q || (emit && last));

  // Template byte at the current position, value bytes and checksum overlaid.
  assign tmpl    = {template_high_i, template_low_i};
  assign tmpl_sh = {4'(pos_q), 3'b000};

  always_comb begin
    if (pos_q == PW'(3)) begin
      body_byte = {cur_q.neg, 7'd0} | {1'b0, form_bits_i} | {4'd0, cur_q.d3};
    end else if (pos_q == PW'(4)) begin
      body_byte = unit_bits_i | {4'd0, cur_q.d2};
    end else if (pos_q == PW'(5)) begin
      body_byte = {cur_q.d1, cur_q.d0};
    end else begin
      body_byte = tmpl[tmpl_sh +: 8];
    end
    cur_byte = last ? sum_q : body_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= emit;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
        pos_q  <= '0;
        sum_q  <= '0;
      end else if (emit) begin
        pos_q <= pos_q + PW'(1);
        sum_q <= sum_q + cur_byte;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (emit) begin
      out_byte_q  <= cur_byte;
      frame_end_q <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;

endmodule

`default_nettype wire

// ===== rtl/decimal_value_frame_builder.sv =====
// Decimal value frame builder.
// Input channel: one signed measurement in tenths per word (value_tenths_i), taken
// at a clock edge with in_valid_i high and in_stall_o low. Each word produces one
// frame of frame_length bytes (clamped to 7..MAX_FRAME) on the output channel,
// one byte per word, frame_end_o marking the checksum byte that closes it.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i; write only
// while no frame is pending. Unknown indexes are ignored.
// Path: the first byte of a frame passes the three digit stages, the queue, the
// sequencer's word register and the output register.
// Throughput: one byte per cycle while out_stall_i is low; frames follow each other
// with no gap; the byte sequencer sets the sustained input rate, one word per frame.
// A four-entry queue between the digit stages and the sequencer absorbs input bursts;
// in_stall_o rises when queue entries plus words in the digit stages reach four.
// When the receiver raises out_stall_i, the output word holds and the sequencer
// waits; input keeps flowing until the queue fills.
// Reset clears the queue, the sequencer and the output valid, and loads the register
// defaults: form bits 64, unit bits 96, frame length 15, template all zero.
`default_nettype none

module decimal_value_frame_builder
  import dvfb_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] value_tenths_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              out_byte_o,
  output logic                    frame_end_o
);

  logic [6:0]   form_bits_q;
  logic [7:0]   unit_bits_q;
  logic [4:0]   frame_length_q;
  logic [63:0]  template_low_q;
  logic [63:0]  template_high_q;

  logic         take;
  logic [1:0]   fe_busy;
  logic         fe_busy3;
  logic         push;
  dvfb_digits_t push_data;
  logic         pop;
  dvfb_qstat_t  qstat;
  dvfb_digits_t head;
  logic [QCNT_W-1:0] committed;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      form_bits_q     <= FORM_BITS_RST;
      unit_bits_q     <= UNIT_BITS_RST;
      frame_length_q  <= FRAME_LENGTH_RST;
      template_low_q  <= '0;
      template_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FORM_BITS:     form_bits_q     <= cfg_data_i[6:0];
        CFG_UNIT_BITS:     unit_bits_q     <= cfg_data_i[7:0];
        CFG_FRAME_LENGTH:  frame_length_q  <= cfg_data_i[4:0];
        CFG_TEMPLATE_LOW:  template_low_q  <= cfg_data_i;
        CFG_TEMPLATE_HIGH: template_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Credit check: every word in the digit stages has a queue entry reserved.
  assign committed  = qstat.count + QCNT_W'(fe_busy[0]) + QCNT_W'(fe_busy[1])
                      + QCNT_W'(fe_busy3);
  assign in_stall_o = (committed >= QCNT_W'(QDEPTH));
  assign take       = in_valid_i && !in_stall_o;

  dvfb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .value_i  (value_tenths_i),
    .busy_o   (fe_busy),
    .busy3_o  (fe_busy3),
    .push_o   (push),
    .digits_o (push_data)
  );

  dvfb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .stat_o      (qstat),
    .head_o      (head)
  );

  dvfb_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .qstat_i         (qstat),
    .head_i          (head),
    .pop_o           (pop),
    .form_bits_i     (form_bits_q),
    .unit_bits_i     (unit_bits_q),
    .frame_length_i  (frame_length_q),
    .template_low_i  (template_low_q),
    .template_high_i (template_high_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .frame_end_o     (frame_end_o)
  );

  // The digit stages never push into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (qstat.count < QCNT_W'(QDEPTH)) || pop)
    else $error("queue push while full");

  // The sequencer only pops a queue that holds a word.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> qstat.valid)
    else $error("queue pop while empty");

  // A full queue holds off the input channel.
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qstat.count == QCNT_W'(QDEPTH)) |-> in_stall_o)
    else $error("input not stalled with queue full");

  // An accepted word reaches the queue after passing through the digit stages.
  a_push_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##3 push)
    else $error("accepted word did not reach the queue");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top
  import dvfb_pkg::*;
();

  localparam int unsigned FRAME_MAX = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned LONG_HOLD = 150;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned MAX_REPORTS = 30;

  // Register indexes that the block does not decode.
  localparam logic [2:0] CFG_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] CFG_LAST_UNUSED = 3'd7;

  // One byte of a frame as the receiver should see it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // Value bytes and checksum typed in by hand for a directed word.
  typedef struct packed {
    logic       pinned;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] chk;
  } value_pin_t;

  // Raw write data for the five registers, plus a write to an undecoded index.
  typedef struct packed {
    logic [63:0] form_data;
    logic [63:0] unit_data;
    logic [63:0] len_data;
    logic [63:0] low_data;
    logic [63:0] high_data;
    logic        junk;
  } settings_t;

  typedef struct packed {
    logic [2:0]  setup;
    logic [15:0] value;
    value_pin_t  pin;
  } directed_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  localparam value_pin_t NO_PIN = '0;

  // Setup 0 is the state after reset and is never written.
  localparam settings_t DIRECTED_SETTINGS [5] = '{
    '{64'(FORM_BITS_RST), 64'(UNIT_BITS_RST), 64'(FRAME_LENGTH_RST), 64'h0, 64'h0, 1'b0},
    '{'1, '1, 64'hFFFF_FFFF_FFFF_FFE7, '1, '1, 1'b0},
    '{64'h0, 64'h0, 64'd16, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1},
    '{64'h15, 64'h0A, 64'h0, 64'h8080_8080_8080_8080, 64'h5A5A_5A5A_5A5A_5A5A, 1'b1},
    '{64'h2A, 64'hC3, 64'h1F, 64'h7F00_FF01_8002_40C0, 64'h0F0F_F0F0_3355_AACC, 1'b0}
  };

  // Words after reset carry their value bytes and checksum; the rest use the predictor.
  localparam directed_row_t DIRECTED_ROWS [22] = '{
    '{3'd0, 16'd0, '{1'b1, 8'h40, 8'h60, 8'h00, 8'hA0}},
    '{3'd0, 16'd1, '{1'b1, 8'h40, 8'h60, 8'h01, 8'hA1}},
    '{3'd0, 16'hFFFF, '{1'b1, 8'hC0, 8'h60, 8'h01, 8'h21}},
    '{3'd0, 16'd9999, '{1'b1, 8'h49, 8'h69, 8'h99, 8'h4B}},
    '{3'd0, -16'sd9999, '{1'b1, 8'hC9, 8'h69, 8'h99, 8'hCB}},
    '{3'd0, 16'd9990, '{1'b1, 8'h49, 8'h69, 8'h90, 8'h42}},
    '{3'd0, 16'd1234, '{1'b1, 8'h41, 8'h62, 8'h34, 8'hD7}},
    '{3'd0, -16'sd5678, '{1'b1, 8'hC5, 8'h66, 8'h78, 8'hA3}},
    '{3'd0, 16'd10000, '{1'b1, 8'h40, 8'h60, 8'h00, 8'hA0}},
    '{3'd0, -16'sd10000, '{1'b1, 8'hC0, 8'h60, 8'h00, 8'h20}},
    '{3'd0, 16'h7FFF, '{1'b1, 8'h40, 8'h60, 8'h00, 8'hA0}},
    '{3'd0, 16'h8000, '{1'b1, 8'hC0, 8'h60, 8'h00, 8'h20}},
    '{3'd1, 16'd0, NO_PIN},
    '{3'd1, 16'd9999, NO_PIN},
    '{3'd1, 16'h8000, NO_PIN},
    '{3'd2, 16'd1234, NO_PIN},
    '{3'd2, 16'hFFFF, NO_PIN},
    '{3'd2, 16'h7FFF, NO_PIN},
    '{3'd3, 16'd5, NO_PIN},
    '{3'd3, -16'sd9999, NO_PIN},
    '{3'd4, 16'd8765, NO_PIN},
    '{3'd4, -16'sd4321, NO_PIN}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_index_i;
  logic [63:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] value_tenths_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         out_byte_o;
  logic               frame_end_o;

  // Register copy kept by the predictor.
  logic [6:0]  form_now = FORM_BITS_RST;
  logic [7:0]  unit_now = UNIT_BITS_RST;
  logic [4:0]  len_now = FRAME_LENGTH_RST;
  logic [63:0] tmpl_lo_now = '0;
  logic [63:0] tmpl_hi_now = '0;

  frame_byte_t frame_bytes[$];
  value_pin_t  value_pins[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          hold_request = 1'b0;

  decimal_value_frame_builder #(
    .MAX_FRAME(FRAME_MAX)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_tenths_i(value_tenths_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .frame_end_o   (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
    mismatches++;
  endtask

  // Builds the frame for one measurement and queues its bytes in sending order.
  function automatic void predict_frame(input logic [15:0] raw, input value_pin_t pin);
    logic [16:0] mag;
    logic [3:0]  d3, d2, d1, d0;
    logic [127:0] tmpl;
    logic [7:0]  fbyte [FRAME_MAX];
    logic [7:0]  sum;
    int unsigned len;
    int unsigned i;
    mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    if (mag > {1'b0, MAX_MAGNITUDE}) begin
      mag = '0;
    end
    d3 = 4'(mag / 1000);
    d2 = 4'((mag / 100) % 10);
    d1 = 4'((mag / 10) % 10);
    d0 = 4'(mag % 10);
    len = len_now;
    if (len < MIN_FRAME) begin
      len = MIN_FRAME;
    end
    if (len > FRAME_MAX) begin
      len = FRAME_MAX;
    end
    tmpl = {tmpl_hi_now, tmpl_lo_now};
    for (i = 0; i < FRAME_MAX; i++) begin
      fbyte[i] = tmpl[8*i +: 8];
    end
    fbyte[3] = {raw[15], form_now} | {4'h0, d3};
    fbyte[4] = unit_now | {4'h0, d2};
    fbyte[5] = {d1, d0};
    if (pin.pinned) begin
      fbyte[3] = pin.b3;
      fbyte[4] = pin.b4;
      fbyte[5] = pin.b5;
    end
    sum = '0;
    for (i = 0; i + 1 < len; i++) begin
      sum += fbyte[i];
    end
    fbyte[len-1] = pin.pinned ? pin.chk : sum;
    for (i = 0; i < len; i++) begin
      frame_bytes.push_back('{data: fbyte[i], last: (i + 1 == len)});
    end
  endfunction

  // Follow register writes, predict accepted words, and check delivered bytes.
  always @(posedge clk_i) begin : scoreboard
    frame_byte_t due;
    if (!rst_ni) begin
      form_now = FORM_BITS_RST;
      unit_now = UNIT_BITS_RST;
      len_now = FRAME_LENGTH_RST;
      tmpl_lo_now = '0;
      tmpl_hi_now = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FORM_BITS: form_now = cfg_data_i[6:0];
          CFG_UNIT_BITS: unit_now = cfg_data_i[7:0];
          CFG_FRAME_LENGTH: len_now = cfg_data_i[4:0];
          CFG_TEMPLATE_LOW: tmpl_lo_now = cfg_data_i;
          CFG_TEMPLATE_HIGH: tmpl_hi_now = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        if (value_pins.size() == 0) begin
          report_mismatch("input word taken that was never offered");
        end else begin
          predict_frame(value_tenths_i, value_pins.pop_front());
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (frame_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_byte_o));
        end else begin
          due = frame_bytes.pop_front();
          if (out_byte_o !== due.data) begin
            report_mismatch($sformatf("byte %02h, predicted %02h", out_byte_o, due.data));
          end
          if (frame_end_o !== due.last) begin
            report_mismatch($sformatf("frame end %b, predicted %b", frame_end_o, due.last));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: switches between stall patterns, with a long hold-off on request.
  initial begin : receiver
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned period;
    int unsigned tick;
    logic        stall_next;
    mode = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    period = 2;
    tick = 0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_e'($urandom_range(3, 0));
          mode_left = $urandom_range(400, 40);
          period = $urandom_range(8, 2);
        end
        mode_left--;
        tick++;
        case (mode)
          STALL_NONE: stall_next = 1'b0;
          STALL_LIGHT: stall_next = ($urandom_range(3, 0) == 0);
          STALL_HEAVY: stall_next = ($urandom_range(3, 0) != 0);
          default: stall_next = ((tick % period) < (period / 2));
        endcase
      end
      out_stall_i <= stall_next;
      @(posedge clk_i);
    end
  end

  function automatic logic [63:0] random_word();
    case ($urandom_range(3, 0))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly displayable magnitudes, some near the limit, some from the full range.
  function automatic logic [15:0] random_value();
    int unsigned v;
    case ($urandom_range(9, 0))
      0, 1: return 16'($urandom);
      2: return 16'($urandom_range(20, 0) - 10);
      3: begin
        v = $urandom_range(10001, 9998);
        return $urandom_range(1, 0) ? 16'(-v) : 16'(v);
      end
      default: return 16'($urandom_range(19998, 0) - 9999);
    endcase
  endfunction

  function automatic settings_t random_settings();
    settings_t s;
    s.form_data = random_word();
    s.unit_data = random_word();
    s.len_data = ($urandom_range(3, 0) != 0) ? 64'($urandom_range(FRAME_MAX, MIN_FRAME))
                                              : random_word();
    s.low_data = random_word();
    s.high_data = random_word();
    s.junk = 1'($urandom_range(1, 0));
    return s;
  endfunction

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input settings_t s);
    write_reg(CFG_FORM_BITS, s.form_data);
    write_reg(CFG_UNIT_BITS, s.unit_data);
    if (s.junk) begin
      write_reg(3'($urandom_range(CFG_LAST_UNUSED, CFG_FIRST_UNUSED)), random_word());
    end
    write_reg(CFG_FRAME_LENGTH, s.len_data);
    write_reg(CFG_TEMPLATE_LOW, s.low_data);
    write_reg(CFG_TEMPLATE_HIGH, s.high_data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Returns at the edge where the word is taken; valid stays high for the caller.
  task automatic offer_word(input logic [15:0] value, input value_pin_t pin);
    value_pins.push_back(pin);
    in_valid_i <= 1'b1;
    value_tenths_i <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Waits until every predicted byte has arrived and the pipeline has settled.
  task automatic wait_idle();
    do @(posedge clk_i); while (value_pins.size() != 0 || frame_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned count, input bit paced,
                                  input bit hold_off, input bit mid_drain);
    int unsigned k;
    int unsigned burst_left;
    int unsigned gap;
    burst_left = $urandom_range(30, 1);
    for (k = 0; k < count; k++) begin
      if (hold_off && k == 2) begin
        hold_request = 1'b1;
      end
      // Halfway through, let the sender pause until the block is empty.
      if (mid_drain && k == count / 2) begin
        in_valid_i <= 1'b0;
        wait_idle();
      end
      offer_word(random_value(), NO_PIN);
      if (paced) begin
        if (burst_left == 0) begin
          gap = $urandom_range(20, 1);
          burst_left = $urandom_range(30, 1);
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end else begin
          burst_left--;
        end
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned i;
    logic [2:0]  setup_now;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_FORM_BITS;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    value_tenths_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed words, back to back, with register changes between groups.
    setup_now = '0;
    for (i = 0; i < $size(DIRECTED_ROWS); i++) begin
      if (DIRECTED_ROWS[i].setup != setup_now) begin
        in_valid_i <= 1'b0;
        wait_idle();
        setup_now = DIRECTED_ROWS[i].setup;
        apply_settings(DIRECTED_SETTINGS[setup_now]);
      end
      offer_word(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].pin);
    end
    in_valid_i <= 1'b0;

    // Random words under fresh register settings in each phase.
    for (i = 0; i < RANDOM_PHASES; i++) begin
      wait_idle();
      apply_settings(random_settings());
      run_random_phase(RANDOM_ITEMS / RANDOM_PHASES, (i % 3) != 0, i == 1 || i == 5, i == 3);
    end
    wait_idle();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
